// ===== sv/pixel_swizzle_unpremultiply_macros.svh =====
// ----------------------------------------------------------------------------
// Pixel swizzle / unpremultiply assertion macros
// Shared property wrappers clocked on i_clk, quiet while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PIXEL_SWIZZLE_UNPREMULTIPLY_MACROS_SVH
`define PIXEL_SWIZZLE_UNPREMULTIPLY_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PSU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/psu_pkg.sv =====
// ----------------------------------------------------------------------------
// psu_pkg
// Types and constants shared by the swizzle front end, the word queue and the
// unpremultiply back end, and the divider step used by the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package psu_pkg;

    localparam int unsigned PIX_W           = 32;
    localparam int unsigned CH_W            = 8;
    localparam int unsigned NUM_COLORS      = 3;
    localparam int unsigned NUM_W           = 2 * CH_W;
    localparam int unsigned DIV_STEP        = 2;
    localparam int unsigned DIV_STAGES      = CH_W / DIV_STEP;
    localparam int unsigned ST_DEPTH        = DIV_STAGES + 1;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;
    localparam int unsigned PADDR_W         = 3;
    localparam int unsigned PDATA_W         = 32;
    localparam logic [CH_W-1:0] CH_MAX      = 8'hff;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_LAYOUT = 1'b0,
        REG_PREMUL = 1'b1
    } t_reg_idx;

    // byte order, from the upper two layout bits
    typedef enum logic [1:0] {
        ORD_KEEP    = 2'd0,
        ORD_SWAP02  = 2'd1,
        ORD_REVERSE = 2'd2,
        ORD_ROTATE  = 2'd3
    } t_order;

    typedef enum logic [1:0] {
        CLS_PASS = 2'd0,
        CLS_ZERO = 2'd1,
        CLS_DIV  = 2'd2
    } t_cls;

    typedef struct packed {
        t_cls             cls;
        logic [PIX_W-1:0] pix;
        logic             row_end;
        logic             frame_end;
    } t_qword;

    typedef struct packed {
        t_cls                              cls;
        logic [PIX_W-1:0]                  pix;
        logic                              row_end;
        logic                              frame_end;
        logic [NUM_COLORS-1:0][NUM_W-1:0]  rem;
        logic [NUM_COLORS-1:0][CH_W-1:0]   quo;
        logic [NUM_COLORS-1:0]             sat;
    } t_work;

    typedef struct packed {
        logic              take;
        logic              head_vld;
        logic              tail_div;
        logic [CH_W-1:0]   tail_alpha;
        logic [NUM_W-1:0]  tail_rem0;
        logic              tail_sat0;
    } t_back_stat;

    // Restoring division over DIV_STEP quotient bits, top bit first.
    function automatic t_work psu_div_step(input t_work w, input int unsigned top);
        t_work            res;
        logic [NUM_W-1:0] dvs;
        int unsigned      bitpos;
        res = w;
        for (int j = 0; j < DIV_STEP; j++) begin
            bitpos = top - j;
            dvs    = NUM_W'(res.pix[PIX_W-1 -: CH_W]) << bitpos;
            for (int c = 0; c < NUM_COLORS; c++) begin
                if (res.rem[c] >= dvs) begin
                    res.rem[c]         = res.rem[c] - dvs;
                    res.quo[c][bitpos] = 1'b1;
                end
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== sv/psu_front.sv =====
// ----------------------------------------------------------------------------
// psu_front
// Configuration registers, byte reorder, alpha forcing and classification of
// each accepted word before it enters the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [psu_pkg::PADDR_W-1:0]   paddr,
    input  logic [psu_pkg::PDATA_W-1:0]   pwdata,
    output logic [psu_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          i_push,
    input  logic [psu_pkg::PIX_W-1:0]     i_pixel,
    input  logic                          i_row_end,
    input  logic                          i_frame_end,
    input  logic                          i_q_full,
    output logic                          o_full,
    output logic                          o_q_wr,
    output psu_pkg::t_qword               o_q_word
);
    import psu_pkg::*;

    logic [2:0]       r_layout, n_layout;
    logic             r_premul, n_premul;
    logic             cfg_wr;
    t_reg_idx         reg_idx;
    t_order           order;
    logic [PIX_W-1:0] swz;
    logic [CH_W-1:0]  alpha;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        n_layout = r_layout;
        n_premul = r_premul;
        if (cfg_wr) begin
            case (reg_idx)
                REG_LAYOUT: n_layout = pwdata[2:0];
                REG_PREMUL: n_premul = pwdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout <= '0;
            r_premul <= 1'b0;
        end else begin
            r_layout <= n_layout;
            r_premul <= n_premul;
        end
    end

    always_comb begin
        case (reg_idx)
            REG_LAYOUT: prdata = PDATA_W'(r_layout);
            REG_PREMUL: prdata = PDATA_W'(r_premul);
            default:    prdata = '0;
        endcase
    end

    assign order = t_order'(r_layout[2:1]);

    always_comb begin
        case (order)
            ORD_KEEP:    swz = i_pixel;
            ORD_SWAP02:  swz = {i_pixel[31:24], i_pixel[7:0], i_pixel[15:8], i_pixel[23:16]};
            ORD_REVERSE: swz = {i_pixel[7:0], i_pixel[15:8], i_pixel[23:16], i_pixel[31:24]};
            ORD_ROTATE:  swz = {i_pixel[7:0], i_pixel[31:8]};
            default:     swz = i_pixel;
        endcase
    end

    assign alpha = swz[PIX_W-1 -: CH_W];

    // force opaque alpha on layouts without it, flag zero-alpha words and words that need the divider
    always_comb begin
        o_q_word.row_end   = i_row_end;
        o_q_word.frame_end = i_frame_end;
        o_q_word.pix       = swz;
        o_q_word.cls       = CLS_PASS;
        if (!r_layout[0]) begin
            o_q_word.pix[PIX_W-1 -: CH_W] = CH_MAX;
        end else if (r_premul) begin
            if (alpha == '0) begin
                o_q_word.cls = CLS_ZERO;
            end else if (alpha != CH_MAX) begin
                o_q_word.cls = CLS_DIV;
            end
        end
    end

    assign o_full = i_q_full;
    assign o_q_wr = i_push && !i_q_full;

endmodule

`default_nettype wire

// ===== sv/psu_queue.sv =====
// ----------------------------------------------------------------------------
// psu_queue
// Small flop queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_queue #(
    parameter int unsigned DEPTH = psu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  psu_pkg::t_qword i_word,
    output logic            o_full,
    input  logic            i_rd,
    output psu_pkg::t_qword o_word,
    output logic            o_empty
);
    import psu_pkg::*;

    localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_qword          r_mem [DEPTH];
    logic [IW-1:0]   r_wp, n_wp;
    logic [IW-1:0]   r_rp, n_rp;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            do_wr, do_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_word  = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_wr) begin
            n_wp = (r_wp == IW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_rd) begin
            n_rp = (r_rp == IW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_wr && !do_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_word;
        end
    end

endmodule

`default_nettype wire

// ===== sv/psu_back.sv =====
// ----------------------------------------------------------------------------
// psu_back
// Unpremultiply pipeline: numerator stage, then a pipelined restoring divider
// that settles two quotient bits per stage. The last stage is the output word.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_avail,
    input  psu_pkg::t_qword            i_word,
    output logic                       o_take,
    output logic                       o_valid,
    input  logic                       i_pop,
    output logic [psu_pkg::PIX_W-1:0]  o_pixel,
    output logic                       o_row_end,
    output logic                       o_frame_end,
    output psu_pkg::t_back_stat        o_stat
);
    import psu_pkg::*;

    localparam int unsigned LAST = ST_DEPTH - 1;

    t_work               r_st [ST_DEPTH];
    t_work               n_st [ST_DEPTH];
    logic [ST_DEPTH-1:0] r_vld, n_vld;
    logic [ST_DEPTH:0]   rdy;
    logic [CH_W-1:0]     in_alpha;
    logic [CH_W-1:0]     col;

    // a stage advances when empty or when the stage after it advances
    always_comb begin
        rdy[ST_DEPTH] = i_pop;
        for (int k = ST_DEPTH - 1; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k + 1];
        end
    end

    assign o_take   = rdy[0];
    assign in_alpha = i_word.pix[PIX_W-1 -: CH_W];

    // numerator c*255 + a/2, and saturate when c >= a
    always_comb begin
        n_st[0].cls       = i_word.cls;
        n_st[0].pix       = i_word.pix;
        n_st[0].row_end   = i_word.row_end;
        n_st[0].frame_end = i_word.frame_end;
        n_st[0].quo       = '0;
        col               = '0;
        for (int c = 0; c < NUM_COLORS; c++) begin
            col            = i_word.pix[c*CH_W +: CH_W];
            n_st[0].rem[c] = {col, {CH_W{1'b0}}} - NUM_W'(col) + NUM_W'(in_alpha >> 1);
            n_st[0].sat[c] = (col >= in_alpha);
        end
        for (int k = 1; k < ST_DEPTH; k++) begin
            n_st[k] = psu_div_step(r_st[k - 1], CH_W - 1 - (k - 1) * DIV_STEP);
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (rdy[0]) begin
            n_vld[0] = i_avail;
        end
        for (int k = 1; k < ST_DEPTH; k++) begin
            if (rdy[k]) begin
                n_vld[k] = r_vld[k - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < ST_DEPTH; k++) begin
            if (rdy[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_valid     = r_vld[LAST];
    assign o_row_end   = r_st[LAST].row_end;
    assign o_frame_end = r_st[LAST].frame_end;

    always_comb begin
        o_pixel = r_st[LAST].pix;
        case (r_st[LAST].cls)
            CLS_PASS: o_pixel = r_st[LAST].pix;
            CLS_ZERO: o_pixel = '0;
            CLS_DIV: begin
                for (int c = 0; c < NUM_COLORS; c++) begin
                    o_pixel[c*CH_W +: CH_W] = r_st[LAST].sat[c] ? CH_MAX : r_st[LAST].quo[c];
                end
            end
            default: o_pixel = r_st[LAST].pix;
        endcase
    end

    assign o_stat.take       = rdy[0];
    assign o_stat.head_vld   = r_vld[0];
    assign o_stat.tail_div   = r_vld[LAST] && (r_st[LAST].cls == CLS_DIV);
    assign o_stat.tail_alpha = r_st[LAST].pix[PIX_W-1 -: CH_W];
    assign o_stat.tail_rem0  = r_st[LAST].rem[0];
    assign o_stat.tail_sat0  = r_st[LAST].sat[0];

endmodule

`default_nettype wire

// ===== sv/pixel_swizzle_unpremultiply.sv =====
// Path: a pushed word is written into the queue, then passes the numerator
// stage and four divider stages before it reaches the result ports.
// Throughput: one word per cycle unless pop stalls; the divider is fully
// pipelined, two quotient bits per stage, and the queue decouples the two sides.
// Reset: synchronous active-low i_rst_n clears layout and premultiplied mode
// to zero and empties the queue and the pipeline.
// ----------------------------------------------------------------------------
// pixel_swizzle_unpremultiply
// Byte reorder to B,G,R,A with optional alpha unpremultiply per pixel word.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pixel_swizzle_unpremultiply_macros.svh"

module pixel_swizzle_unpremultiply #(
    parameter int unsigned QUEUE_DEPTH = psu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_pixel_in,
    input  logic        i_row_end_in,
    input  logic        i_frame_end_in,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_pixel_out,
    output logic        o_row_end_out,
    output logic        o_frame_end_out
);
    import psu_pkg::*;

    logic       q_full, q_wr, q_empty;
    t_qword     q_in, q_out;
    t_back_stat back_stat;
    logic       back_valid;
    logic       back_take;

    psu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_push      (push),
        .i_pixel     (i_pixel_in),
        .i_row_end   (i_row_end_in),
        .i_frame_end (i_frame_end_in),
        .i_q_full    (q_full),
        .o_full      (full),
        .o_q_wr      (q_wr),
        .o_q_word    (q_in)
    );

    psu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_word  (q_in),
        .o_full  (q_full),
        .i_rd    (back_take),
        .o_word  (q_out),
        .o_empty (q_empty)
    );

    psu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_avail     (!q_empty),
        .i_word      (q_out),
        .o_take      (back_take),
        .o_valid     (back_valid),
        .i_pop       (pop),
        .o_pixel     (o_pixel_out),
        .o_row_end   (o_row_end_out),
        .o_frame_end (o_frame_end_out),
        .o_stat      (back_stat)
    );

    assign empty = !back_valid;

    `PSU_ASSERT_NEXT(a_push_fills_queue, push && !full, !q_empty, "accepted word missing from queue")
    `PSU_ASSERT_NEXT(a_head_loads, !q_empty && back_stat.take, back_stat.head_vld, "queued word not taken into pipeline")
    `PSU_ASSERT_SAME(a_div_remainder, back_stat.tail_div && !back_stat.tail_sat0, back_stat.tail_rem0 < 16'(back_stat.tail_alpha), "divider remainder not below alpha")

endmodule

`default_nettype wire

// ===== test/pixel_swizzle_unpremultiply_checker.sv =====
// ----------------------------------------------------------------------------
// pixel_swizzle_unpremultiply_checker
// Watches the register port and both word interfaces of the swizzle block. It
// keeps its own copy of layout and premultiplied mode, predicts the B,G,R,A
// word for every accepted input word and compares each popped word with the
// oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_swizzle_unpremultiply_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [31:0] i_pixel_in,
    input  logic        i_row_end_in,
    input  logic        i_frame_end_in,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [31:0] i_pixel_out,
    input  logic        i_row_end_out,
    input  logic        i_frame_end_out,
    output int          o_fail_count,
    output int          o_words_pending
);
    import psu_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [31:0] pixel;
        logic        row_end;
        logic        frame_end;
    } t_bgra_word;

    t_bgra_word  expected_words[$];
    t_bgra_word  want;
    t_bgra_word  pushed;
    logic [2:0]  layout_q;
    logic        premul_q;

    // Restore a straight-alpha color: round to nearest, clamp at full scale.
    function automatic logic [7:0] divide_by_alpha(input logic [7:0] c, input logic [7:0] a);
        int unsigned q;
        q = (int'(c) * 255 + int'(a >> 1)) / int'(a);
        return (q > 255) ? CH_MAX : q[7:0];
    endfunction

    function automatic logic [31:0] bgra_from_source(input logic [2:0] layout,
                                                      input logic premul,
                                                      input logic [31:0] src);
        t_order      ord;
        logic [31:0] w;
        logic [7:0]  a;
        ord = t_order'(layout[2:1]);
        case (ord)
            ORD_KEEP:    w = src;
            ORD_SWAP02:  w = {src[31:24], src[7:0], src[15:8], src[23:16]};
            ORD_REVERSE: w = {src[7:0], src[15:8], src[23:16], src[31:24]};
            default:     w = {src[7:0], src[31:8]};
        endcase
        // odd layouts carry alpha, even ones get it forced opaque
        if (!layout[0]) begin
            w[31:24] = CH_MAX;
        end else if (premul) begin
            a = w[31:24];
            if (a == 8'd0) begin
                w = '0;
            end else if (a != CH_MAX) begin
                w = {a, divide_by_alpha(w[23:16], a), divide_by_alpha(w[15:8], a),
                     divide_by_alpha(w[7:0], a)};
            end
        end
        return w;
    endfunction

    initial begin
        o_fail_count    = 0;
        o_words_pending = 0;
        layout_q        = '0;
        premul_q        = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            layout_q = '0;
            premul_q = 1'b0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[2]))
                    REG_LAYOUT: layout_q = i_pwdata[2:0];
                    REG_PREMUL: premul_q = i_pwdata[0];
                    default: ;
                endcase
            end
            if (i_push && !i_full) begin
                pushed.pixel     = bgra_from_source(layout_q, premul_q, i_pixel_in);
                pushed.row_end   = i_row_end_in;
                pushed.frame_end = i_frame_end_in;
                expected_words.insert(expected_words.size(), pushed);
            end
            if (i_pop && !i_empty) begin
                if (expected_words.size() == 0) begin
                    if (o_fail_count < MAX_REPORTS)
                        $display("checker: word %h row %b frame %b popped with none expected",
                                 i_pixel_out, i_row_end_out, i_frame_end_out);
                    o_fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (want.pixel !== i_pixel_out || want.row_end !== i_row_end_out ||
                        want.frame_end !== i_frame_end_out) begin
                        if (o_fail_count < MAX_REPORTS)
                            $display("checker: expected %h/%b/%b got %h/%b/%b",
                                     want.pixel, want.row_end, want.frame_end,
                                     i_pixel_out, i_row_end_out, i_frame_end_out);
                        o_fail_count++;
                    end
                end
            end
        end
        o_words_pending = expected_words.size();
    end

endmodule

`default_nettype wire

// ===== test/pixel_swizzle_unpremultiply_tb.sv =====
// ----------------------------------------------------------------------------
// pixel_swizzle_unpremultiply_tb
// Drives pixel words through the swizzle / unpremultiply block under every
// layout and alpha mode, with random gaps on the push side and random stalls
// on the pop side. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_swizzle_unpremultiply_tb;

    import psu_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int PHASE_COUNT     = 20;
    localparam int WORDS_PER_PHASE = 35;

    localparam logic [2:0] ADDR_LAYOUT = {REG_LAYOUT, 2'b00};
    localparam logic [2:0] ADDR_PREMUL = {REG_PREMUL, 2'b00};

    localparam logic [2:0] LAYOUT_BGRX = 3'd0;
    localparam logic [2:0] LAYOUT_BGRA = 3'd1;
    localparam logic [2:0] LAYOUT_RGBX = 3'd2;
    localparam logic [2:0] LAYOUT_RGBA = 3'd3;
    localparam logic [2:0] LAYOUT_XRGB = 3'd4;
    localparam logic [2:0] LAYOUT_ARGB = 3'd5;
    localparam logic [2:0] LAYOUT_XBGR = 3'd6;
    localparam logic [2:0] LAYOUT_ABGR = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        push;
    logic        full;
    logic [31:0] i_pixel_in;
    logic        i_row_end_in;
    logic        i_frame_end_in;
    logic        empty;
    logic        pop;
    logic [31:0] o_pixel_out;
    logic        o_row_end_out;
    logic        o_frame_end_out;

    int fail_count;
    int words_pending;
    int cycle_count;
    bit push_burst;
    bit pop_burst;

    pixel_swizzle_unpremultiply dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .push(push), .full(full),
        .i_pixel_in(i_pixel_in), .i_row_end_in(i_row_end_in),
        .i_frame_end_in(i_frame_end_in),
        .empty(empty), .pop(pop),
        .o_pixel_out(o_pixel_out), .o_row_end_out(o_row_end_out),
        .o_frame_end_out(o_frame_end_out)
    );

    pixel_swizzle_unpremultiply_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .i_push(push), .i_full(full),
        .i_pixel_in(i_pixel_in), .i_row_end_in(i_row_end_in),
        .i_frame_end_in(i_frame_end_in),
        .i_empty(empty), .i_pop(pop),
        .i_pixel_out(o_pixel_out), .i_row_end_out(o_row_end_out),
        .i_frame_end_out(o_frame_end_out),
        .o_fail_count(fail_count), .o_words_pending(words_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // Pop side: random stalls per word, with runs of back-to-back pops.
    initial begin
        int stall;
        pop       = 1'b0;
        pop_burst = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 31) == 0)
                pop_burst = ~pop_burst;
            stall = pop_burst ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                pop = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            pop = 1'b1;
            do @(posedge i_clk); while (empty);
            @(negedge i_clk);
        end
    end

    // Called at a falling edge; returns at the falling edge after the write.
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Drain the block, then load a new layout and alpha mode.
    task automatic set_mode(input logic [2:0] layout, input logic premul);
        push = 1'b0;
        while (words_pending != 0) @(negedge i_clk);
        apb_write(ADDR_LAYOUT, {29'd0, layout});
        apb_write(ADDR_PREMUL, {31'd0, premul});
    endtask

    // Called at a falling edge; leaves push high, so the caller must either
    // send the next word or drop push at that same falling edge.
    task automatic send_word(input logic [31:0] pixel, input logic row_end,
                             input logic frame_end);
        int gap;
        if ($urandom_range(0, 31) == 0)
            push_burst = ~push_burst;
        gap = push_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_pixel_in     = pixel;
        i_row_end_in   = row_end;
        i_frame_end_in = frame_end;
        push           = 1'b1;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
    endtask

    // Mostly well-formed premultiplied words (colors no larger than alpha),
    // alpha placed where this layout reads it; the rest is pure noise.
    function automatic logic [31:0] random_pixel(input logic [2:0] layout);
        logic [31:0] w;
        logic [7:0]  a;
        int          pick;
        pick = $urandom_range(0, 9);
        if (pick >= 8)
            return $urandom;
        case (pick)
            0:       a = 8'h00;
            1:       a = CH_MAX;
            2:       a = 8'h01;
            default: a = 8'($urandom_range(0, 255));
        endcase
        for (int i = 0; i < 4; i++)
            w[8*i +: 8] = 8'($urandom_range(0, a));
        if (layout[2])
            w[7:0] = a;
        else
            w[31:24] = a;
        return w;
    endfunction

    logic [31:0] rgba_cases[11] = '{
        32'h0000_0000, 32'hffff_ffff, 32'h00ff_ffff, 32'hff00_0000,
        32'h0101_0101, 32'h01ff_00ff, 32'h0201_0001, 32'h8040_6080,
        32'hfefe_fefe, 32'h7fff_8001, 32'hfe00_0000
    };
    logic [2:0] other_layouts[7] = '{
        LAYOUT_BGRX, LAYOUT_BGRA, LAYOUT_RGBX, LAYOUT_XRGB,
        LAYOUT_ARGB, LAYOUT_XBGR, LAYOUT_ABGR
    };

    initial begin
        logic [2:0] layout;
        logic       premul;
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        push           = 1'b0;
        i_pixel_in     = '0;
        i_row_end_in   = 1'b0;
        i_frame_end_in = 1'b0;
        push_burst     = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // alpha corner cases: zero, opaque, one, clamping, rounding
        set_mode(LAYOUT_RGBA, 1'b1);
        foreach (rgba_cases[k])
            send_word(rgba_cases[k], k[0], k[1]);
        foreach (other_layouts[k]) begin
            set_mode(other_layouts[k], 1'b1);
            send_word(32'h1234_5678, 1'b1, 1'b0);
            send_word(32'h8765_4321, 1'b0, 1'b1);
        end

        // every layout with both modes, then random settings
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            if (ph < 16) begin
                layout = ph[2:0];
                premul = ph[3];
            end else begin
                layout = 3'($urandom_range(0, 7));
                premul = 1'($urandom_range(0, 1));
            end
            set_mode(layout, premul);
            repeat (WORDS_PER_PHASE)
                send_word(random_pixel(layout), $urandom_range(0, 3) == 0,
                          1'($urandom_range(0, 1)));
        end
        push = 1'b0;

        while (words_pending != 0) @(negedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && words_pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
